>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rnsgd_pkg.sv
// Shared types and constants of the ReLU neuron with momentum SGD.
package rnsgd_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_FORWARD = 3'd1,
    CMD_OUT_ERR = 3'd2,
    CMD_HID_ERR = 3'd3,
    CMD_UPDATE  = 3'd4
  } cmd_e;

  localparam logic KIND_ACT  = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  localparam int unsigned APB_AW = 3;
  localparam logic        REG_LR = 1'b0;
  localparam logic        REG_MF = 1'b1;

  localparam logic [15:0] LR_RESET = 16'd655;
  localparam logic [15:0] MF_RESET = 16'd58982;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               start;
    logic signed [31:0] grad;
    logic signed [31:0] xin;
    logic signed [31:0] wgt;
    logic signed [31:0] mom;
    logic [15:0]        lr;
    logic [15:0]        mf;
  } upd_req_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [31:0] wgt;
    logic signed [31:0] mom;
  } upd_rsp_t;

endpackage

>>> hw/rtl/relu_neuron_sgd_momentum.sv
// Steps: a load writes the RAM at once; an output error goes through the emit state;
// forward and hidden elements multiply, then 64-bit accumulate; the last adds FIN and EMIT.
// Update elements: RAM read, then the four-stage update unit
// (two chained multiplies) before the weight/momentum write-back.
// One item at a time; the output register frees the input side while a result waits.
// Reset clears control, accumulator and config; weight/momentum/input RAMs are not cleared.
module relu_neuron_sgd_momentum #(
  parameter int unsigned MAX_INPUTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    command_i,
  input  logic signed [31:0]            value_i,
  input  logic signed [31:0]            link_weight_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic signed [31:0]            result_value_o,
  output logic                          overflowed_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rnsgd_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  `include "assert_macros.svh"

  localparam int unsigned IdxW  = $clog2(MAX_INPUTS + 1);
  localparam int unsigned AddrW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_UPD_GO,
    ST_UPD_WAIT,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [IdxW-1:0]    idx_q;
  logic [AddrW-1:0]   addr_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] pre_q, grad_q;
  logic               sticky_q;
  logic [15:0]        lr_q, mf_q;
  logic signed [31:0] val_q, link_q;
  logic               fwd_q, last_q;
  logic signed [63:0] prod_q;
  logic               res_kind_q, res_flag_q;
  logic signed [31:0] res_val_q;
  logic               out_valid_q, out_kind_q, out_flag_q;
  logic signed [31:0] out_val_q;

  logic               in_fire, cfg_wr, in_range;
  logic [AddrW-1:0]   addr;
  logic               wm_we, x_we;
  logic [AddrW-1:0]   wm_waddr;
  logic [63:0]        wm_wdata, wm_rdata;
  logic [31:0]        x_rdata;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_d;
  logic signed [64:0] acc_sum;
  logic               acc_ovf;
  logic signed [63:0] acc_sat;
  logic signed [47:0] fin_sh;
  logic               fin_sat;
  logic signed [31:0] fin_s;
  logic               fin_pos, pre_pos;

  rnsgd_pkg::upd_req_t upd_req;
  rnsgd_pkg::upd_rsp_t upd_rsp;

  // Handshakes and element addressing
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign in_range   = (idx_q < IdxW'(MAX_INPUTS));
  assign addr       = idx_q[AddrW-1:0];

  // Weight and momentum share one RAM word: momentum in the upper half
  assign wm_we    = (in_fire && (command_i == rnsgd_pkg::CMD_LOAD) && in_range) || upd_rsp.done;
  assign wm_waddr = upd_rsp.done ? addr_q : addr;
  assign wm_wdata = upd_rsp.done ? {upd_rsp.mom, upd_rsp.wgt} : {32'd0, value_i};
  assign x_we     = in_fire && (command_i == rnsgd_pkg::CMD_FORWARD) && in_range;

  rnsgd_ram #(
    .Width (64),
    .Depth (MAX_INPUTS)
  ) u_wm_ram (
    .clk_i   (clk_i),
    .we_i    (wm_we),
    .waddr_i (wm_waddr),
    .wdata_i (wm_wdata),
    .re_i    (in_fire),
    .raddr_i (addr),
    .rdata_o (wm_rdata)
  );

  rnsgd_ram #(
    .Width (32),
    .Depth (MAX_INPUTS)
  ) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (addr),
    .wdata_i (value_i),
    .re_i    (in_fire),
    .raddr_i (addr),
    .rdata_o (x_rdata)
  );

  // Update unit input, weight and momentum operands arrive straight from the RAM read registers
  assign upd_req.start = (state_q == ST_UPD_GO);
  assign upd_req.grad  = grad_q;
  assign upd_req.xin   = x_rdata;
  assign upd_req.wgt   = wm_rdata[31:0];
  assign upd_req.mom   = wm_rdata[63:32];
  assign upd_req.lr    = lr_q;
  assign upd_req.mf    = mf_q;

  rnsgd_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (upd_req),
    .rsp_o  (upd_rsp)
  );

  // Multiply, saturating accumulate and final Q16.16 scaling
  always_comb begin
    mul_b   = fwd_q ? wm_rdata[31:0] : link_q;
    prod_d  = val_q * mul_b;
    acc_sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};
    acc_ovf = acc_sum[64] ^ acc_sum[63];
    if (acc_ovf) begin
      acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sat = acc_sum[63:0];
    end
    fin_sh  = acc_q[63:16];
    fin_sat = !((&fin_sh[47:31]) || !(|fin_sh[47:31]));
    if (fin_sat) begin
      fin_s = fin_sh[47] ? rnsgd_pkg::Q_MIN : rnsgd_pkg::Q_MAX;
    end else begin
      fin_s = fin_sh[31:0];
    end
    fin_pos = !fin_s[31] && (|fin_s);
    pre_pos = !pre_q[31] && (|pre_q);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= rnsgd_pkg::LR_RESET;
      mf_q <= rnsgd_pkg::MF_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rnsgd_pkg::REG_LR: lr_q <= pwdata[15:0];
        rnsgd_pkg::REG_MF: mf_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == rnsgd_pkg::REG_MF) ? {16'd0, mf_q} : {16'd0, lr_q};
  assign pready = 1'b1;

  // Sequencer: state, run bookkeeping and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      addr_q      <= '0;
      acc_q       <= '0;
      pre_q       <= '0;
      grad_q      <= '0;
      sticky_q    <= 1'b0;
      val_q       <= '0;
      link_q      <= '0;
      fwd_q       <= 1'b0;
      last_q      <= 1'b0;
      prod_q      <= '0;
      res_kind_q  <= rnsgd_pkg::KIND_ACT;
      res_val_q   <= '0;
      res_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= rnsgd_pkg::KIND_ACT;
      out_val_q   <= '0;
      out_flag_q  <= 1'b0;
    end else begin
      // Drop the result once the transfer completes; a waiting result reloads it below
      if (out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            // Advance the element index for known commands, or clear it on the last element or an output error
            if (command_i <= rnsgd_pkg::CMD_UPDATE) begin
              if (last_i || (command_i == rnsgd_pkg::CMD_OUT_ERR)) begin
                idx_q <= '0;
              end else if (in_range) begin
                idx_q <= idx_q + IdxW'(1);
              end
            end
            unique case (command_i)
              rnsgd_pkg::CMD_LOAD: begin
                if (!in_range) begin
                  sticky_q <= 1'b1;
                end
              end
              rnsgd_pkg::CMD_FORWARD: begin
                if (idx_q == '0) begin
                  acc_q <= '0;
                end
                val_q  <= value_i;
                fwd_q  <= 1'b1;
                last_q <= last_i;
                if (in_range) begin
                  state_q <= ST_MUL;
                end else begin
                  sticky_q <= 1'b1;
                  if (last_i) begin
                    state_q <= ST_FIN;
                  end
                end
              end
              rnsgd_pkg::CMD_OUT_ERR: begin
                grad_q     <= pre_pos ? value_i : '0;
                res_val_q  <= pre_pos ? value_i : '0;
                res_kind_q <= rnsgd_pkg::KIND_GRAD;
                res_flag_q <= sticky_q;
                sticky_q   <= 1'b0;
                state_q    <= ST_EMIT;
              end
              rnsgd_pkg::CMD_HID_ERR: begin
                if (idx_q == '0) begin
                  acc_q <= '0;
                end
                val_q   <= value_i;
                link_q  <= link_weight_i;
                fwd_q   <= 1'b0;
                last_q  <= last_i;
                state_q <= ST_MUL;
              end
              rnsgd_pkg::CMD_UPDATE: begin
                if (in_range) begin
                  addr_q  <= addr;
                  state_q <= ST_UPD_GO;
                end else begin
                  sticky_q <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q <= acc_sat;
          if (acc_ovf) begin
            sticky_q <= 1'b1;
          end
          state_q <= last_q ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          res_flag_q <= fin_sat || sticky_q;
          sticky_q   <= 1'b0;
          acc_q      <= '0;
          if (fwd_q) begin
            pre_q      <= fin_s;
            res_kind_q <= rnsgd_pkg::KIND_ACT;
            res_val_q  <= fin_pos ? fin_s : '0;
          end else begin
            grad_q     <= pre_pos ? fin_s : '0;
            res_kind_q <= rnsgd_pkg::KIND_GRAD;
            res_val_q  <= pre_pos ? fin_s : '0;
          end
          state_q <= ST_EMIT;
        end
        ST_UPD_GO: begin
          state_q <= ST_UPD_WAIT;
        end
        ST_UPD_WAIT: begin
          if (upd_rsp.done) begin
            if (upd_rsp.sat) begin
              sticky_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // Hold the result until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= res_kind_q;
            out_val_q   <= res_val_q;
            out_flag_q  <= res_flag_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign result_value_o = out_val_q;
  assign overflowed_o   = out_flag_q;

  // Checks on sequencing
  `ASSERT_ALWAYS(a_idx_bound, clk_i, rst_ni, idx_q <= IdxW'(MAX_INPUTS), "element index past limit")
  `ASSERT_IMPL(a_wm_write_src, clk_i, rst_ni, wm_we, (state_q == ST_IDLE) || (state_q == ST_UPD_WAIT), "weight RAM written outside load or write-back")
  `ASSERT_IMPL(a_upd_done_wait, clk_i, rst_ni, upd_rsp.done, state_q == ST_UPD_WAIT, "update result with no waiting element")
  `ASSERT_NEXT(a_emit_load, clk_i, rst_ni, (state_q == ST_EMIT) && (!out_valid_o || out_ready_i), out_valid_o && (state_q == ST_IDLE), "result not loaded into output register")

endmodule

>>> hw/rtl/rnsgd_ram.sv
// Generic single-port-write, registered-read RAM.
module rnsgd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rnsgd_update.sv
// Four-stage weight and momentum update unit.
module rnsgd_update (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rnsgd_pkg::upd_req_t req_i,
  output rnsgd_pkg::upd_rsp_t rsp_o
);

  logic               v1_q, v2_q, v3_q, done_q;
  logic signed [63:0] tprod_q;
  logic signed [48:0] bprod_q;
  logic signed [31:0] w1_q, w2_q, w3_q;
  logic signed [63:0] aprod_q;
  logic signed [32:0] b_q;
  logic signed [31:0] upd_q;
  logic               sat3_q;
  logic signed [31:0] wnew_q, mom_q;
  logic               sat_q;

  logic signed [47:0] t_s2;
  logic signed [47:0] a_s3;
  logic signed [48:0] diff_s3;
  logic               dsat_s3;
  logic signed [31:0] upd_s3;
  logic signed [32:0] wsum_s4;
  logic               wsat_s4;
  logic signed [31:0] wnew_s4;

  // Shift products back to Q16.16 and saturate
  always_comb begin
    t_s2    = tprod_q[63:16];
    a_s3    = aprod_q[63:16];
    diff_s3 = {{16{b_q[32]}}, b_q} - {a_s3[47], a_s3};
    dsat_s3 = !((&diff_s3[48:31]) || !(|diff_s3[48:31]));
    if (dsat_s3) begin
      upd_s3 = diff_s3[48] ? rnsgd_pkg::Q_MIN : rnsgd_pkg::Q_MAX;
    end else begin
      upd_s3 = diff_s3[31:0];
    end
    wsum_s4 = {w3_q[31], w3_q} + {upd_q[31], upd_q};
    wsat_s4 = wsum_s4[32] ^ wsum_s4[31];
    if (wsat_s4) begin
      wnew_s4 = wsum_s4[32] ? rnsgd_pkg::Q_MIN : rnsgd_pkg::Q_MAX;
    end else begin
      wnew_s4 = wsum_s4[31:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= req_i.start;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      tprod_q <= req_i.grad * req_i.xin;
      bprod_q <= req_i.mom * $signed({1'b0, req_i.mf});
      w1_q    <= req_i.wgt;
    end
    if (v1_q) begin
      aprod_q <= t_s2 * $signed({1'b0, req_i.lr});
      b_q     <= bprod_q[48:16];
      w2_q    <= w1_q;
    end
    if (v2_q) begin
      upd_q  <= upd_s3;
      sat3_q <= dsat_s3;
      w3_q   <= w2_q;
    end
    if (v3_q) begin
      wnew_q <= wnew_s4;
      mom_q  <= upd_q;
      sat_q  <= sat3_q || wsat_s4;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.wgt  = wnew_q;
  assign rsp_o.mom  = mom_q;

endmodule
